@@ rtl/tcr_pkg.sv @@
`default_nettype none
package tcr_pkg;

    localparam int NUM_ANGLES   = 8;
    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef struct packed {
        logic done;
        logic skew;
    } t_bld_stat;

endpackage
`default_nettype wire

@@ rtl/tcr_cordic.sv @@
`default_nettype none
module tcr_cordic #(
    parameter int ANGLE_BITS = 16,
    parameter int COEF_BITS  = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ANGLE_BITS-1:0]       i_angle,
    output logic                             o_done,
    output logic signed [COEF_BITS-1:0]      o_sin,
    output logic signed [COEF_BITS-1:0]      o_cos
);
    localparam int CW = tcr_pkg::CW;
    localparam int QS = ANGLE_BITS - 2;
    localparam int SH = 31 - COEF_BITS;
    localparam logic signed [CW-1:0] CMAX_W = CW'((64'sd1 <<< (COEF_BITS-1)) - 64'sd1);
    localparam logic signed [COEF_BITS-1:0] CMAX = COEF_BITS'(CMAX_W);

    logic                 r_busy;
    logic                 r_done;
    logic [3:0]           r_i;
    logic [1:0]           r_q;
    logic                 r_zero;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic signed [CW-1:0] w_dx, w_dy, w_at;
    logic signed [COEF_BITS-1:0] w_s0, w_c0;

    function automatic logic signed [COEF_BITS-1:0] rnd(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = (v + (CW'(1) <<< (SH-1))) >>> SH;
        if (t > CMAX_W)
            return CMAX;
        else if (t < -CMAX_W)
            return -CMAX;
        else
            return COEF_BITS'(t);
    endfunction

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = $signed(CW'(tcr_pkg::ATAN_TURN[r_i]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 4'd1;
                if (r_i == 4'(tcr_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
            r_zero <= (i_angle[QS-1:0] == '0);
            r_x    <= tcr_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= $signed(CW'(i_angle[QS-1:0]) << (32 - ANGLE_BITS));
        end else if (r_busy) begin
            if (!r_z[CW-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    // exact quadrant angle skips the rotation result
    assign w_s0 = r_zero ? '0   : rnd(r_y);
    assign w_c0 = r_zero ? CMAX : rnd(r_x);

    always_comb begin
        unique case (r_q)
            2'd0: begin o_sin = w_s0;  o_cos = w_c0;  end
            2'd1: begin o_sin = w_c0;  o_cos = -w_s0; end
            2'd2: begin o_sin = -w_s0; o_cos = -w_c0; end
            default: begin o_sin = -w_c0; o_cos = w_s0; end
        endcase
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

@@ rtl/tcr_builder.sv @@
`default_nettype none
module tcr_builder #(
    parameter int ANGLE_BITS = 16,
    parameter int COEF_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [1:0]             i_target,
    input  wire logic [ANGLE_BITS-1:0]  i_angle [tcr_pkg::NUM_ANGLES],
    output tcr_pkg::t_bld_stat          o_stat,
    output logic signed [COEF_BITS-1:0] o_coef [9]
);
    localparam int NA = tcr_pkg::NUM_ANGLES;
    localparam int PW = 2*COEF_BITS + 2;
    localparam int LAST_STEP = 21;
    localparam logic [1:0] TGT_XYZ = 2'd0;
    localparam logic [1:0] TGT_VNE = 2'd1;
    localparam logic [1:0] TGT_VRT = 2'd2;
    localparam logic signed [PW-1:0] CMAX_W = PW'((64'sd1 <<< (COEF_BITS-1)) - 64'sd1);
    localparam logic signed [COEF_BITS-1:0] CMAX = COEF_BITS'(CMAX_W);
    localparam logic signed [PW-1:0] SKEW_TOL = PW'(8) <<< (COEF_BITS-1);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_SC   = 3'b010,
        B_MAT  = 3'b100
    } t_bstate;

    t_bstate r_state;
    logic [2:0] r_k;
    logic       r_cstart;
    logic [4:0] r_step;
    logic       r_done;
    logic       r_skew;
    logic signed [COEF_BITS-1:0] r_sn [NA];
    logic signed [COEF_BITS-1:0] r_cs [NA];
    logic signed [COEF_BITS-1:0] r_b0 [3];
    logic signed [COEF_BITS-1:0] r_b1 [3];
    logic signed [COEF_BITS-1:0] r_m  [4];
    logic signed [COEF_BITS-1:0] r_coef [9];

    logic                        w_cdone;
    logic signed [COEF_BITS-1:0] w_csin, w_ccos;
    logic signed [COEF_BITS-1:0] w_bs [3][3];
    logic signed [COEF_BITS-1:0] w_t  [3][3];
    logic signed [COEF_BITS-1:0] w_a  [3];
    logic signed [COEF_BITS-1:0] w_b  [3];
    logic signed [2*COEF_BITS-1:0] w_p [3];
    logic signed [PW-1:0] w_sum, w_abs, w_sh;
    logic signed [COEF_BITS-1:0] w_rnd;

    tcr_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_angle (i_angle[r_k]),
        .o_done  (w_cdone),
        .o_sin   (w_csin),
        .o_cos   (w_ccos)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_bs[0][i] = r_b0[i];
            w_bs[1][i] = r_b1[i];
            w_bs[2][i] = r_cs[2*i];
        end
    end

    // target matrix, angles 6 and 7 are back azimuth and lqt angle
    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                w_t[i][j] = '0;
        unique case (i_target)
            TGT_XYZ: begin
                for (int i = 0; i < 3; i++) w_t[i][i] = CMAX;
            end
            TGT_VNE: begin
                for (int i = 0; i < 3; i++) w_t[i][2-i] = CMAX;
            end
            TGT_VRT: begin
                w_t[0][2] = CMAX;
                w_t[1][0] = -r_sn[6]; w_t[1][1] = -r_cs[6];
                w_t[2][0] = -r_cs[6]; w_t[2][1] = r_sn[6];
            end
            default: begin
                w_t[0][0] = -r_m[0]; w_t[0][1] = -r_m[1]; w_t[0][2] = r_cs[7];
                w_t[1][0] = -r_m[2]; w_t[1][1] = -r_m[3]; w_t[1][2] = -r_sn[7];
                w_t[2][0] = -r_cs[6]; w_t[2][1] = r_sn[6];
            end
        endcase
    end

    // operand select for the shared three-term dot unit
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_a[k] = '0;
            w_b[k] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            if (r_step == 5'(2*i)) begin
                w_a[0] = r_sn[2*i]; w_b[0] = r_sn[2*i+1];
            end
            if (r_step == 5'(2*i+1)) begin
                w_a[0] = r_sn[2*i]; w_b[0] = r_cs[2*i+1];
            end
        end
        if (r_step == 5'd6) begin w_a[0] = r_sn[6]; w_b[0] = r_sn[7]; end
        if (r_step == 5'd7) begin w_a[0] = r_cs[6]; w_b[0] = r_sn[7]; end
        if (r_step == 5'd8) begin w_a[0] = r_sn[6]; w_b[0] = r_cs[7]; end
        if (r_step == 5'd9) begin w_a[0] = r_cs[6]; w_b[0] = r_cs[7]; end
        for (int k = 0; k < 3; k++) begin
            if (r_step == 5'd10) begin w_a[k] = w_bs[0][k]; w_b[k] = w_bs[1][k]; end
            if (r_step == 5'd11) begin w_a[k] = w_bs[1][k]; w_b[k] = w_bs[2][k]; end
            if (r_step == 5'd12) begin w_a[k] = w_bs[0][k]; w_b[k] = w_bs[2][k]; end
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (r_step == 5'(13 + 3*i + j))
                    for (int k = 0; k < 3; k++) begin
                        w_a[k] = w_t[i][k];
                        w_b[k] = w_bs[k][j];
                    end
    end

    always_comb begin
        for (int k = 0; k < 3; k++)
            w_p[k] = w_a[k] * w_b[k];
        w_sum = PW'(w_p[0]) + PW'(w_p[1]) + PW'(w_p[2]);
        w_abs = w_sum[PW-1] ? -w_sum : w_sum;
        w_sh  = (w_sum + (PW'(1) <<< (COEF_BITS-2))) >>> (COEF_BITS-1);
        if (w_sh > CMAX_W)
            w_rnd = CMAX;
        else if (w_sh < -CMAX_W)
            w_rnd = -CMAX;
        else
            w_rnd = COEF_BITS'(w_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_k      <= '0;
            r_cstart <= 1'b0;
            r_step   <= '0;
            r_done   <= 1'b0;
            r_skew   <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_cstart <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_state  <= B_SC;
                        r_k      <= '0;
                        r_cstart <= 1'b1;
                        r_skew   <= 1'b0;
                    end
                end
                B_SC: begin
                    if (w_cdone) begin
                        if (r_k == 3'(NA - 1)) begin
                            r_state <= B_MAT;
                            r_step  <= '0;
                        end else begin
                            r_k      <= r_k + 3'd1;
                            r_cstart <= 1'b1;
                        end
                    end
                end
                B_MAT: begin
                    if (r_step >= 5'd10 && r_step <= 5'd12 && w_abs >= SKEW_TOL)
                        r_skew <= 1'b1;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(LAST_STEP)) begin
                        r_state <= B_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_SC && w_cdone) begin
            r_sn[r_k] <= w_csin;
            r_cs[r_k] <= w_ccos;
        end
        if (r_state == B_MAT) begin
            priority if (r_step < 5'd6) begin
                if (r_step[0])
                    r_b1[r_step[2:1]] <= w_rnd;
                else
                    r_b0[r_step[2:1]] <= w_rnd;
            end else if (r_step < 5'd10) begin
                r_m[2'(r_step - 5'd6)] <= w_rnd;
            end else if (r_step >= 5'd13) begin
                r_coef[4'(r_step - 5'd13)] <= w_rnd;
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.skew = r_skew;
    assign o_coef      = r_coef;

endmodule
`default_nettype wire

@@ rtl/tcr_lane.sv @@
`default_nettype none
module tcr_lane #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [COEF_BITS-1:0]   i_coef   [3],
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample [3],
    output logic signed [SAMPLE_BITS+1:0]      o_value
);
    localparam int OB = SAMPLE_BITS + 2;
    localparam int PB = COEF_BITS + SAMPLE_BITS;
    localparam int AW = PB + 2;
    localparam logic signed [AW-1:0] OMAX = AW'((64'sd1 <<< (OB-1)) - 64'sd1);

    logic signed [PB-1:0] w_p [3];
    logic signed [AW-1:0] w_acc, w_sh;
    logic signed [OB-1:0] w_sat;
    logic signed [OB-1:0] r_value;

    always_comb begin
        for (int k = 0; k < 3; k++)
            w_p[k] = i_coef[k] * i_sample[k];
        w_acc = AW'(w_p[0]) + AW'(w_p[1]) + AW'(w_p[2]);
        w_sh  = (w_acc + (AW'(1) <<< (COEF_BITS-2))) >>> (COEF_BITS-1);
        if (w_sh > OMAX)
            w_sat = OB'(OMAX);
        else if (w_sh < -OMAX - AW'(1))
            w_sat = OB'(-OMAX - AW'(1));
        else
            w_sat = OB'(w_sh);
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_value <= w_sat;
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

@@ rtl/three_component_rotation.sv @@
`default_nettype none
// Rotates three-component samples into XYZ, VNE, VRT or LQT. After reset or any write to a
// defined register the first word triggers a one-time matrix build: eight sine/cosine
// evaluations on a single iterative CORDIC and 22 steps on one shared dot-product unit. After
// that three lanes, one per output component, take one word per cycle while the receiver
// does not stall; each word is registered in the sample register, then in the lane output
// registers. tuser carries the orthogonality flag of the sensor basis with every word.
module three_component_rotation #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16,
    parameter int ANGLE_BITS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // sample_first, sample_second, sample_third
    input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // rotated_first, rotated_second, rotated_third
    output logic [((3*(SAMPLE_BITS+2)+7)/8)*8-1:0] o_m_tdata,
    // not_orthogonal
    output logic                      o_m_tuser,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [2*ANGLE_BITS-1:0] i_cfg_data
);
    localparam int OB     = SAMPLE_BITS + 2;
    localparam int OUT_DW = ((3*OB+7)/8)*8;
    localparam logic [2:0] REG_TARGET  = 3'd0;
    localparam logic [2:0] REG_LQT     = 3'd1;
    localparam logic [2:0] REG_BAZ     = 3'd2;
    localparam logic [2:0] REG_ORIENT0 = 3'd3;
    localparam logic [2:0] REG_ORIENT1 = 3'd4;
    localparam logic [2:0] REG_ORIENT2 = 3'd5;

    logic [1:0]              r_target;
    logic [ANGLE_BITS-1:0]   r_lqt, r_baz;
    logic [2*ANGLE_BITS-1:0] r_orient [3];
    logic                    r_ready;
    logic                    r_building;
    logic                    r_smp_valid;
    logic signed [SAMPLE_BITS-1:0] r_smp [3];
    logic                    r_ov;
    logic                    r_flag;

    logic [ANGLE_BITS-1:0]   w_angle [tcr_pkg::NUM_ANGLES];
    tcr_pkg::t_bld_stat      w_stat;
    logic signed [COEF_BITS-1:0] w_coef [9];
    logic signed [OB-1:0]    w_out [3];
    logic                    w_fire, w_start, w_in_acc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_angle[2*i]   = r_orient[i][2*ANGLE_BITS-1:ANGLE_BITS];
            w_angle[2*i+1] = r_orient[i][ANGLE_BITS-1:0];
        end
        w_angle[6] = r_baz;
        w_angle[7] = r_lqt;
    end

    assign w_fire     = r_smp_valid && r_ready && (!r_ov || i_m_tready);
    assign w_start    = r_smp_valid && !r_ready && !r_building;
    assign o_s_tready = !r_smp_valid || w_fire;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 2'd1;
            r_lqt       <= '0;
            r_baz       <= '0;
            r_orient[0] <= '0;
            r_orient[1] <= '0;
            r_orient[2] <= '0;
            r_ready     <= 1'b0;
            r_building  <= 1'b0;
            r_smp_valid <= 1'b0;
            r_ov        <= 1'b0;
            r_flag      <= 1'b0;
        end else begin
            if (w_start)
                r_building <= 1'b1;
            if (w_stat.done) begin
                r_building <= 1'b0;
                r_ready    <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TARGET:  begin r_target <= i_cfg_data[1:0]; r_ready <= 1'b0; end
                    REG_LQT:     begin r_lqt <= i_cfg_data[ANGLE_BITS-1:0]; r_ready <= 1'b0; end
                    REG_BAZ:     begin r_baz <= i_cfg_data[ANGLE_BITS-1:0]; r_ready <= 1'b0; end
                    REG_ORIENT0: begin r_orient[0] <= i_cfg_data; r_ready <= 1'b0; end
                    REG_ORIENT1: begin r_orient[1] <= i_cfg_data; r_ready <= 1'b0; end
                    REG_ORIENT2: begin r_orient[2] <= i_cfg_data; r_ready <= 1'b0; end
                    default: ;
                endcase
            end
            if (w_in_acc)
                r_smp_valid <= 1'b1;
            else if (w_fire)
                r_smp_valid <= 1'b0;
            if (w_fire) begin
                r_ov   <= 1'b1;
                r_flag <= w_stat.skew;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc)
            for (int i = 0; i < 3; i++)
                r_smp[i] <= $signed(i_s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]);
    end

    tcr_builder #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_builder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_target (r_target),
        .i_angle  (w_angle),
        .o_stat   (w_stat),
        .o_coef   (w_coef)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic signed [COEF_BITS-1:0] w_row [3];
        always_comb begin
            for (int k = 0; k < 3; k++)
                w_row[k] = w_coef[3*g + k];
        end
        tcr_lane #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_fire),
            .i_coef   (w_row),
            .i_sample (r_smp),
            .o_value  (w_out[g])
        );
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_flag;
    assign o_m_tdata  = OUT_DW'({w_out[2], w_out[1], w_out[0]});

endmodule
`default_nettype wire

@@ rtl/tcr_checker.sv @@
`default_nettype none
module tcr_port_props #(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_m_tvalid,
    input wire logic i_m_tready,
    input wire logic [((3*(SAMPLE_BITS+2)+7)/8)*8-1:0] o_m_tdata,
    input wire logic o_m_tuser
);
    localparam int OB = SAMPLE_BITS + 2;

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output word changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata >> (3*OB)) == '0))
        else $error("tdata padding not zero");

endmodule

bind three_component_rotation tcr_port_props #(.SAMPLE_BITS(SAMPLE_BITS)) u_tcr_port_props (.*);
`default_nettype wire

@@ tb/tcr_checker.sv @@
module tcr_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [71:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [79:0] i_m_tdata,
    input  wire logic        i_m_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam longint COEF_LIM = 32767;
    localparam longint OUT_LIM  = (64'sd1 <<< 25) - 1;
    localparam longint SKEW_LIM = 64'sd8 <<< 15;

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0, REG_LQT = 3'd1, REG_BAZ = 3'd2,
        REG_ORIENT1 = 3'd3, REG_ORIENT2 = 3'd4, REG_ORIENT3 = 3'd5
    } t_reg;
    typedef enum logic [1:0] {SYS_XYZ = 2'd0, SYS_VNE = 2'd1, SYS_VRT = 2'd2, SYS_LQT = 2'd3}
        t_sys;

    typedef struct packed {
        logic [25:0] third;
        logic [25:0] second;
        logic [25:0] first;
        logic        skew;
    } t_rotated;

    localparam longint ARC [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    t_sys        sys = SYS_VNE;
    logic [15:0] lqt = '0;
    logic [15:0] baz = '0;
    logic [31:0] orient [3] = '{default: '0};
    longint      coef [9] = '{default: 0};
    logic        built = 1'b0;
    logic        skewed = 1'b0;
    t_rotated    expected_words [$];

    function automatic longint to_coef(longint v, int sh);
        longint r;
        r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (r > COEF_LIM) r = COEF_LIM;
        if (r < -COEF_LIM) r = -COEF_LIM;
        return r;
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
        longint x, y, z, dx, dy, s0, c0;
        if (ang[13:0] == 0) begin
            s0 = 0;
            c0 = COEF_LIM;
        end else begin
            x = 652032874;
            y = 0;
            z = longint'(ang[13:0]) <<< 16;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= ARC[i];
                end else begin
                    x += dx; y -= dy; z += ARC[i];
                end
            end
            s0 = to_coef(y, 15);
            c0 = to_coef(x, 15);
        end
        case (ang[15:14])
            2'd0: begin sn = s0;  cs = c0;  end
            2'd1: begin sn = c0;  cs = -s0; end
            2'd2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
    endfunction

    function automatic void build_rotation();
        longint b [3][3];
        longint t [3][3];
        longint si, ci, sa, ca, sb, cb, d, acc;
        for (int i = 0; i < 3; i++) begin
            sin_cos(orient[i][31:16], si, ci);
            sin_cos(orient[i][15:0], sa, ca);
            b[0][i] = to_coef(si * sa, 15);
            b[1][i] = to_coef(si * ca, 15);
            b[2][i] = ci;
        end
        skewed = 1'b0;
        for (int p = 0; p < 3; p++) begin
            d = 0;
            for (int k = 0; k < 3; k++)
                d += (p == 1) ? b[1][k] * b[2][k] : b[0][k] * b[p == 0 ? 1 : 2][k];
            if (d < 0) d = -d;
            if (d >= SKEW_LIM) skewed = 1'b1;
        end
        foreach (t[i, j]) t[i][j] = 0;
        sin_cos(baz, sb, cb);
        case (sys)
            SYS_XYZ: for (int i = 0; i < 3; i++) t[i][i] = COEF_LIM;
            SYS_VNE: for (int i = 0; i < 3; i++) t[i][2-i] = COEF_LIM;
            SYS_VRT: begin
                t[0][2] = COEF_LIM;
                t[1][0] = -sb; t[1][1] = -cb;
                t[2][0] = -cb; t[2][1] = sb;
            end
            default: begin
                sin_cos(lqt, si, ci);
                t[0][0] = -to_coef(sb * si, 15); t[0][1] = -to_coef(cb * si, 15);
                t[0][2] = ci;
                t[1][0] = -to_coef(sb * ci, 15); t[1][1] = -to_coef(cb * ci, 15);
                t[1][2] = -si;
                t[2][0] = -cb; t[2][1] = sb;
            end
        endcase
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += t[i][k] * b[k][j];
                coef[i*3+j] = to_coef(acc, 15);
            end
        built = 1'b1;
    endfunction

    function automatic t_rotated rotate_word(logic [71:0] w);
        longint smp [3];
        longint acc;
        t_rotated r;
        logic [25:0] f [3];
        for (int i = 0; i < 3; i++) smp[i] = longint'($signed(w[i*24 +: 24]));
        if (!built) build_rotation();
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += coef[i*3+k] * smp[k];
            acc = (acc + (64'sd1 <<< 14)) >>> 15;
            if (acc > OUT_LIM) acc = OUT_LIM;
            if (acc < -OUT_LIM - 1) acc = -OUT_LIM - 1;
            f[i] = acc[25:0];
        end
        r.first = f[0];
        r.second = f[1];
        r.third = f[2];
        r.skew = skewed;
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_rotated got, want;
        if (i_rst_n) begin
            if (i_cfg_we && i_cfg_idx <= REG_ORIENT3) begin
                case (t_reg'(i_cfg_idx))
                    REG_TARGET: sys = t_sys'(i_cfg_data[1:0]);
                    REG_LQT:    lqt = i_cfg_data[15:0];
                    REG_BAZ:    baz = i_cfg_data[15:0];
                    default:    orient[i_cfg_idx - REG_ORIENT1] = i_cfg_data;
                endcase
                built = 1'b0;
            end
            if (i_s_tvalid && i_s_tready) expected_words.push_back(rotate_word(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[77:52], i_m_tdata[51:26], i_m_tdata[25:0], i_m_tuser};
                if (expected_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected word %h", got);
                end else begin
                    want = expected_words.pop_front();
                    if (got != want || i_m_tdata[79:78] != 2'b00) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp %0d %0d %0d skew %b, got %0d %0d %0d skew %b",
                                $signed(want.first), $signed(want.second),
                                $signed(want.third), want.skew, $signed(got.first),
                                $signed(got.second), $signed(got.third), got.skew);
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

@@ tb/tb.sv @@
module tb;

    localparam logic [2:0] REG_TARGET = 3'd0, REG_LQT = 3'd1, REG_BAZ = 3'd2,
                           REG_ORIENT1 = 3'd3, REG_ORIENT2 = 3'd4, REG_ORIENT3 = 3'd5,
                           REG_NONE = 3'd6, REG_SPARE = 3'd7;
    localparam logic [15:0] QUARTER = 16'd16384;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic        calm = 1'b0;
    int          fail_count, pending, stall_left = 0;

    three_component_rotation i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    tcr_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial forever #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver back-pressure in bursts
    always @(posedge i_clk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(logic [23:0] a, logic [23:0] b, logic [23:0] c);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // pending is sampled away from the rising edge so the checker has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] sys, logic [31:0] lqt, logic [31:0] baz,
                           logic [31:0] o1, logic [31:0] o2, logic [31:0] o3);
        drain();
        write_reg(REG_TARGET, sys);
        write_reg(REG_LQT, lqt);
        write_reg(REG_BAZ, baz);
        write_reg(REG_ORIENT1, o1);
        write_reg(REG_ORIENT2, o2);
        write_reg(REG_ORIENT3, o3);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random();
        logic [23:0] v [3];
        for (int i = 0; i < 3; i++)
            case ($urandom_range(0, 5))
                0: v[i] = 24'h7fffff;
                1: v[i] = 24'h800000;
                2: v[i] = 24'($urandom_range(0, 255));
                default: v[i] = 24'($urandom);
            endcase
        send_word(v[0], v[1], v[2]);
    endtask

    initial begin
        logic [15:0] a;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: degenerate all-vertical basis
        send_word(24'h7fffff, 24'h800000, 24'h000000);
        send_word(24'h800000, 24'h7fffff, 24'hffffff);
        // zne basis under every target, extreme angles
        for (int s = 0; s < 4; s++) begin
            set_all(s, (s == 3) ? 32'h8000 : 32'h0, (s == 2) ? 32'hffff : 32'h0,
                    32'h0, {QUARTER, 16'h0}, {QUARTER, QUARTER});
            send_word(24'h7fffff, 24'h7fffff, 24'h7fffff);
            send_word(24'h800000, 24'h800000, 24'h800000);
            send_word(24'h000001, 24'hfffffe, 24'h123456);
        end
        set_all(SYS_LQT_CODE(), 32'hffff7fff, 32'h2000, 32'h0, {QUARTER, 16'h1234},
                {QUARTER, 16'h5234});
        send_word(24'h400000, 24'hc00000, 24'h7fffff);
        // unknown index is ignored, and rewriting a register rebuilds
        drain();
        write_reg(REG_NONE, 32'hffffffff);
        write_reg(REG_SPARE, 32'h0);
        write_reg(REG_BAZ, 32'h2000);
        cfg_we <= 1'b0;
        send_word(24'h400000, 24'hc00000, 24'h7fffff);

        for (int ph = 0; ph < 15; ph++) begin
            a = 16'($urandom);
            if ($urandom_range(0, 2) != 0)
                set_all($urandom, $urandom, $urandom, {16'h0, 16'($urandom)},
                        {QUARTER, a}, {QUARTER, 16'(a + QUARTER)});
            else
                set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            if (ph == 12) calm <= 1'b1;
            repeat (30) send_random();
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    function automatic logic [31:0] SYS_LQT_CODE();
        return 32'd3;
    endfunction

endmodule
